FILE: rtl/pdtc_pkg.sv
// Shared types, sizes and helper functions of the periodic dart-throw checker.
`default_nettype none
package pdtc_pkg;

  localparam int MAX_PARTICLES = 256;
  localparam int COORD_BITS    = 16;

  localparam int SLOT_BITS   = $clog2(MAX_PARTICLES);
  localparam int COUNT_BITS  = $clog2(MAX_PARTICLES + 1);
  localparam int TARGET_BITS = 9;
  localparam int TGT_W       = (COUNT_BITS > TARGET_BITS) ? COUNT_BITS : TARGET_BITS;
  localparam int RAD_BITS    = 15;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 3;

  // Distance datapath widths.
  localparam int SQ_W  = 2 * COORD_BITS;
  localparam int SUM_W = SQ_W + 2;
  localparam int RSQ_W = 2 * RAD_BITS;
  localparam int LIM_W = RSQ_W + 4;
  localparam int CMP_W = (SUM_W > LIM_W) ? SUM_W : LIM_W;

  // Latency of the distance unit, from sample to registered hit flag.
  localparam int SEP_LAT   = 4;
  localparam int WALK_LAST = MAX_PARTICLES + SEP_LAT - 1;
  localparam int CNT_W     = $clog2(WALK_LAST + 1);

  // Result field widths on the output stream.
  localparam int SLOT_OUT_BITS  = 8;
  localparam int TOTAL_OUT_BITS = 9;
  localparam int OUT_FIELD_W    = 1 + 2 + SLOT_OUT_BITS + TOTAL_OUT_BITS + 1;
  localparam int OUT_TDATA_W    = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int IN_FIELD_W     = 3 * COORD_BITS;
  localparam int IN_TDATA_W     = ((IN_FIELD_W + 7) / 8) * 8;

  typedef struct packed {
    logic [COORD_BITS-1:0] z;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] x;
  } pos_t;

  typedef enum logic [1:0] {
    VERDICT_PLACED    = 2'd0,
    VERDICT_TOO_CLOSE = 2'd1,
    VERDICT_SET_FULL  = 2'd2,
    VERDICT_OUTSIDE   = 2'd3
  } verdict_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET = 3'd0,
    REG_BOX_X  = 3'd1,
    REG_BOX_Y  = 3'd2,
    REG_BOX_Z  = 3'd3,
    REG_RADIUS = 3'd4
  } cfg_reg_e;

  function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                      input logic [COORD_BITS-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Minimum-image separation of one axis from the plain difference.
  function automatic logic [COORD_BITS-1:0] min_image(input logic [COORD_BITS-1:0] d,
                                                       input logic [COORD_BITS-1:0] len);
    logic [COORD_BITS:0] two_d;
    two_d = {d, 1'b0};
    if (two_d <= {1'b0, len}) begin
      return d;
    end else if (d > len) begin
      return d - len;
    end else begin
      return len - d;
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/periodic_dart_throw_checker.sv
// Top level of the periodic dart-throw checker: ring of stored particles and control.
//
//   channel   | direction | handshake          | payload
//   ----------+-----------+--------------------+-------------------------------------
//   s_axis    | in        | s_tvalid/s_tready  | tdata: cand_x, cand_y, cand_z; tuser: restart
//   m_axis    | out       | m_tvalid/m_tready  | tdata: accepted, verdict, slot, total, full
//   cfg       | in        | cfg_we_i           | cfg_idx_i selects, cfg_wdata_i data
//
// A candidate that is tested has its result loaded into the output register once
// the ring of stored positions has made one full turn past a single distance unit,
// one entry per cycle, the 4-stage unit has drained, and the finish state has found
// the output register free. Outside-box and set-full candidates go from the accept
// cycle straight to the finish state. A finished result waits in the output register
// while the downstream side stalls; a new request is taken once the result has been
// loaded there. Reset clears control state and loads the configuration defaults;
// ring cells hold garbage until written, and only slots below the placed count are
// ever used.
`default_nettype none
module periodic_dart_throw_checker
  import pdtc_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // candidate stream
  input  wire logic                   s_tvalid_i,
  output logic                        s_tready_o,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata_i,   // cand_x, cand_y, cand_z
  input  wire logic                   s_tuser_i,   // restart
  // result stream
  output logic                        m_tvalid_o,
  input  wire logic                   m_tready_i,
  output logic [OUT_TDATA_W-1:0]      m_tdata_o,   // accepted, verdict, slot_index,
                                                   // placed_total, set_full, zero pad
  // configuration writes
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_W-1:0]       cfg_wdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_WALK   = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  localparam int PAD_W = OUT_TDATA_W - OUT_FIELD_W;

  // Configuration registers.
  logic [TARGET_BITS-1:0] target_q;
  pos_t                   box_q;
  logic [RAD_BITS-1:0]    radius_q;
  logic [RSQ_W-1:0]       rsq_q;
  logic [LIM_W-1:0]       lim_q;

  // Control state.
  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [COUNT_BITS-1:0]  count_q, count_d;
  verdict_e               pend_q, pend_d;
  logic                   hit_seen_q, hit_seen_d;
  pos_t                   cand_q;

  // Output register.
  logic                      m_valid_q, m_valid_d;
  logic                      acc_q;
  verdict_e                  verd_q;
  logic [SLOT_OUT_BITS-1:0]  slot_q;
  logic [TOTAL_OUT_BITS-1:0] total_q;
  logic                      full_q;

  logic                  in_accept;
  logic                  out_free;
  logic                  out_load;
  logic                  place_now;
  logic [TGT_W-1:0]      tgt;
  logic [COUNT_BITS-1:0] count_eff;
  logic                  outside;
  logic                  full_in;
  pos_t                  cand_in;
  verdict_e              final_verdict;
  logic [COUNT_BITS-1:0] total_after;
  logic                  rotate;
  logic                  sample;
  logic                  hit;

  pos_t                  ring_pos [MAX_PARTICLES];
  logic [MAX_PARTICLES-1:0] load_en;

  // ---------------------------------------------------------------------------
  // Configuration: write by index, ignore unknown indexes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TARGET_BITS'(1);
      box_q.x  <= COORD_BITS'(1280);
      box_q.y  <= COORD_BITS'(1280);
      box_q.z  <= COORD_BITS'(1280);
      radius_q <= RAD_BITS'(256);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TARGET: target_q <= cfg_wdata_i[TARGET_BITS-1:0];
        REG_BOX_X:  box_q.x  <= cfg_wdata_i[COORD_BITS-1:0];
        REG_BOX_Y:  box_q.y  <= cfg_wdata_i[COORD_BITS-1:0];
        REG_BOX_Z:  box_q.z  <= cfg_wdata_i[COORD_BITS-1:0];
        REG_RADIUS: radius_q <= cfg_wdata_i[RAD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Exclusion limit 9*r^2, registered through rsq_q and then lim_q after a radius write.
  always_ff @(posedge clk_i) begin
    rsq_q <= radius_q * radius_q;
    lim_q <= LIM_W'({rsq_q, 3'b000}) + LIM_W'(rsq_q);
  end

  // ---------------------------------------------------------------------------
  // Input side checks, done in the accept cycle.
  assign s_tready_o = (state_q == ST_IDLE);
  assign in_accept  = s_tvalid_i && s_tready_o;

  assign cand_in.x = s_tdata_i[COORD_BITS-1:0];
  assign cand_in.y = s_tdata_i[2*COORD_BITS-1:COORD_BITS];
  assign cand_in.z = s_tdata_i[3*COORD_BITS-1:2*COORD_BITS];

  // Clamp the target to the ring capacity.
  assign tgt = (TGT_W'(target_q) > TGT_W'(MAX_PARTICLES)) ? TGT_W'(MAX_PARTICLES)
                                                          : TGT_W'(target_q);

  assign count_eff = s_tuser_i ? '0 : count_q;
  assign outside   = (cand_in.x > box_q.x) || (cand_in.y > box_q.y) ||
                     (cand_in.z > box_q.z);
  assign full_in   = (TGT_W'(count_eff) >= tgt);

  // ---------------------------------------------------------------------------
  // Walk: turn the ring once, feed each live slot to the distance unit.
  assign rotate = (state_q == ST_WALK) && (cnt_q < CNT_W'(MAX_PARTICLES));
  assign sample = rotate && (cnt_q < CNT_W'(count_q));

  assign final_verdict = ((pend_q == VERDICT_PLACED) && hit_seen_q) ? VERDICT_TOO_CLOSE
                                                                    : pend_q;

  assign out_free    = !m_valid_q || m_tready_i;
  assign out_load    = (state_q == ST_FINISH) && out_free;
  assign place_now   = out_load && (final_verdict == VERDICT_PLACED);
  assign total_after = count_q + COUNT_BITS'(place_now);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    pend_d     = pend_q;
    hit_seen_d = hit_seen_q;
    count_d    = count_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          cnt_d      = '0;
          hit_seen_d = 1'b0;
          count_d    = count_eff;
          if (outside) begin
            pend_d  = VERDICT_OUTSIDE;
            state_d = ST_FINISH;
          end else if (full_in) begin
            pend_d  = VERDICT_SET_FULL;
            state_d = ST_FINISH;
          end else begin
            pend_d  = VERDICT_PLACED;
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        // Collect hits as they leave the distance pipeline.
        hit_seen_d = hit_seen_q || hit;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(WALK_LAST)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Hold until the output register is free.
        if (out_load) begin
          count_d = total_after;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      count_q    <= '0;
      pend_q     <= VERDICT_PLACED;
      hit_seen_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      count_q    <= count_d;
      pend_q     <= pend_d;
      hit_seen_q <= hit_seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cand_q <= cand_in;
    end
  end

  // ---------------------------------------------------------------------------
  // Ring of storage cells; cell 0 faces the distance unit.
  for (genvar i = 0; i < MAX_PARTICLES; i++) begin : g_ring
    localparam int NXT = (i + 1) % MAX_PARTICLES;

    assign load_en[i] = place_now && (count_q[SLOT_BITS-1:0] == SLOT_BITS'(i));

    pdtc_cell u_cell (
      .clk_i      (clk_i),
      .shift_i    (rotate),
      .nb_i       (ring_pos[NXT]),
      .load_i     (load_en[i]),
      .load_pos_i (cand_q),
      .pos_o      (ring_pos[i])
    );
  end

  pdtc_dist u_dist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (sample),
    .cand_i   (cand_q),
    .stored_i (ring_pos[0]),
    .box_i    (box_q),
    .lim_i    (lim_q),
    .hit_o    (hit)
  );

  // ---------------------------------------------------------------------------
  // Output register.
  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      acc_q   <= place_now;
      verd_q  <= final_verdict;
      slot_q  <= place_now ? SLOT_OUT_BITS'(count_q) : '0;
      total_q <= TOTAL_OUT_BITS'(total_after);
      full_q  <= (TGT_W'(total_after) >= tgt);
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = {{PAD_W{1'b0}}, full_q, total_q, slot_q, verd_q, acc_q};

  // ---------------------------------------------------------------------------
`ifndef SYNTH
  a_place_bumps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    place_now |=> (count_q == $past(count_q) + 1'b1))
    else $error("placed count did not advance on a stored particle");

  a_full_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && state_d == ST_FINISH) |-> (cnt_q == CNT_W'(WALK_LAST)))
    else $error("walk left before the ring turned fully and drained");

  a_drained_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !hit)
    else $error("distance unit reports a hit outside a walk");
`endif

endmodule
`default_nettype wire

FILE: rtl/pdtc_cell.sv
// One storage cell of the particle ring: holds one placed position.
`default_nettype none
module pdtc_cell
  import pdtc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic shift_i,
  input  wire pos_t nb_i,
  input  wire logic load_i,
  input  wire pos_t load_pos_i,
  output pos_t      pos_o
);

  pos_t pos_q;

  // Load a new particle, or take the neighbor's position while the ring turns.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pos_q <= load_pos_i;
    end else if (shift_i) begin
      pos_q <= nb_i;
    end
  end

  assign pos_o = pos_q;

endmodule
`default_nettype wire

FILE: rtl/pdtc_dist.sv
// Pipelined minimum-image distance test of a candidate against one stored position.
`default_nettype none
module pdtc_dist
  import pdtc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire pos_t             cand_i,
  input  wire pos_t             stored_i,
  input  wire pos_t             box_i,
  input  wire logic [LIM_W-1:0] lim_i,
  output logic                  hit_o
);

  logic             v1_q, v2_q, v3_q, hit_q;
  pos_t             diff_q;
  pos_t             sep_q;
  logic [SQ_W-1:0]  sqx_q, sqy_q, sqz_q;
  logic [SUM_W-1:0] sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      v1_q  <= valid_i;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      hit_q <= v3_q && (CMP_W'(sum) < CMP_W'(lim_i));
    end
  end

  // Difference, wrap, square; sum and compare feed the hit flag.
  always_ff @(posedge clk_i) begin
    diff_q.x <= abs_diff(cand_i.x, stored_i.x);
    diff_q.y <= abs_diff(cand_i.y, stored_i.y);
    diff_q.z <= abs_diff(cand_i.z, stored_i.z);
    sep_q.x  <= min_image(diff_q.x, box_i.x);
    sep_q.y  <= min_image(diff_q.y, box_i.y);
    sep_q.z  <= min_image(diff_q.z, box_i.z);
    sqx_q    <= sep_q.x * sep_q.x;
    sqy_q    <= sep_q.y * sep_q.y;
    sqz_q    <= sep_q.z * sep_q.z;
  end

  assign sum   = SUM_W'(sqx_q) + SUM_W'(sqy_q) + SUM_W'(sqz_q);
  assign hit_o = hit_q;

endmodule
`default_nettype wire

FILE: tb/sv/pdtc_scoreboard_pkg.sv
// Placement predictor and result scoreboard for the periodic dart-throw checker testbench.
`timescale 1ns / 1ps
package pdtc_scoreboard_pkg;
  import pdtc_pkg::*;

  localparam int SLOT_LSB  = 3;
  localparam int TOTAL_LSB = SLOT_LSB + SLOT_OUT_BITS;
  localparam int FULL_BIT  = TOTAL_LSB + TOTAL_OUT_BITS;

  typedef struct packed {
    logic                      accepted;
    verdict_e                  verdict;
    logic [SLOT_OUT_BITS-1:0]  slot;
    logic [TOTAL_OUT_BITS-1:0] total;
    logic                      full;
  } outcome_t;

  class placement_scoreboard;
    int unsigned           target_count;
    int unsigned           box_len [3];
    int unsigned           radius;
    logic [COORD_BITS-1:0] slot_pos [MAX_PARTICLES][3];
    int unsigned           placed_count;
    outcome_t              expected_outcomes [$];
    int unsigned           errors;
    int unsigned           verdict_tally [4];

    function new();
      target_count = 1;
      box_len      = '{1280, 1280, 1280};
      radius       = 256;
      placed_count = 0;
      errors       = 0;
      verdict_tally = '{0, 0, 0, 0};
    endfunction

    function void set_register(cfg_reg_e idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_TARGET: target_count = value[TARGET_BITS-1:0];
        REG_BOX_X:  box_len[0]   = value;
        REG_BOX_Y:  box_len[1]   = value;
        REG_BOX_Z:  box_len[2]   = value;
        REG_RADIUS: radius       = value[RAD_BITS-1:0];
        default: ;
      endcase
    endfunction

    // Minimum-image separation on one periodic axis.
    function longint unsigned wrap_sep(int unsigned a, int unsigned b, int unsigned len);
      longint unsigned d;
      d = (a > b) ? a - b : b - a;
      if (2 * d <= len) return d;
      return (d > len) ? d - len : len - d;
    endfunction

    function int unsigned pending();
      return expected_outcomes.size();
    endfunction

    // Judge one accepted candidate and queue the outcome the block must report.
    function void note_candidate(bit restart, logic [COORD_BITS-1:0] cx,
                                 logic [COORD_BITS-1:0] cy, logic [COORD_BITS-1:0] cz);
      logic [COORD_BITS-1:0] c [3];
      int unsigned           goal;
      longint unsigned       lim;
      longint unsigned       sep_sq;
      outcome_t              o;
      c[0] = cx;
      c[1] = cy;
      c[2] = cz;
      if (restart) placed_count = 0;
      goal = (target_count > MAX_PARTICLES) ? MAX_PARTICLES : target_count;
      o = '0;
      o.verdict = VERDICT_PLACED;
      if (cx > box_len[0] || cy > box_len[1] || cz > box_len[2]) begin
        o.verdict = VERDICT_OUTSIDE;
      end else if (placed_count >= goal) begin
        o.verdict = VERDICT_SET_FULL;
      end else begin
        lim = 64'(radius) * radius * 9;
        for (int k = 0; k < placed_count; k++) begin
          sep_sq = 0;
          for (int a = 0; a < 3; a++) begin
            longint unsigned s;
            s = wrap_sep(c[a], slot_pos[k][a], box_len[a]);
            sep_sq += s * s;
          end
          if (sep_sq < lim) begin
            o.verdict = VERDICT_TOO_CLOSE;
            break;
          end
        end
        if (o.verdict == VERDICT_PLACED) begin
          for (int a = 0; a < 3; a++) slot_pos[placed_count][a] = c[a];
          o.accepted = 1'b1;
          o.slot = placed_count[SLOT_OUT_BITS-1:0];
          placed_count++;
        end
      end
      o.total = placed_count[TOTAL_OUT_BITS-1:0];
      o.full  = (placed_count >= goal);
      expected_outcomes.push_back(o);
    endfunction

    function void compare_field(string field, logic [8:0] want, logic [8:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    // Compare one result from the block with the oldest queued outcome.
    function void check_result(logic [OUT_TDATA_W-1:0] data);
      outcome_t want;
      if (expected_outcomes.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending: expected none, actual %h", $time, data);
        return;
      end
      want = expected_outcomes.pop_front();
      verdict_tally[want.verdict]++;
      compare_field("accepted", 9'(want.accepted), 9'(data[0]));
      compare_field("verdict", 9'(want.verdict), 9'(data[2:1]));
      compare_field("slot_index", 9'(want.slot), 9'(data[SLOT_LSB +: SLOT_OUT_BITS]));
      compare_field("placed_total", want.total, data[TOTAL_LSB +: TOTAL_OUT_BITS]);
      compare_field("set_full", 9'(want.full), 9'(data[FULL_BIT]));
    endfunction
  endclass

endpackage

FILE: tb/sv/tb_top.sv
// Top of the periodic dart-throw checker testbench: clock, reset, stimulus and checks.
`timescale 1ns / 1ps
module tb_top;
  import pdtc_pkg::*;
  import pdtc_scoreboard_pkg::*;

  // Generous run limit: several times the slowest legal run.
  localparam int unsigned CYCLE_LIMIT  = 1_500_000;
  // Long downstream stall; several tested candidates fit into it.
  localparam int unsigned HOLD_CYCLES  = 1500;
  // Quiet time at the end, sized from the ring length and the distance unit latency.
  localparam int unsigned DRAIN_CYCLES = 2 * (MAX_PARTICLES + SEP_LAT + 1);

  logic                   clk_i;
  logic                   rst_ni      = 1'b0;
  logic                   s_tvalid_i  = 1'b0;
  logic                   s_tready_o;
  logic [IN_TDATA_W-1:0]  s_tdata_i   = '0;
  logic                   s_tuser_i   = 1'b0;
  logic                   m_tvalid_o;
  logic                   m_tready_i  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata_o;
  logic                   cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i   = '0;
  logic [CFG_W-1:0]       cfg_wdata_i = '0;

  placement_scoreboard sb = new();

  bit          calm         = 1'b0;  // no idling on either side while set
  bit          hold_request = 1'b0;  // ask the receiver for one long stall
  bit          hold_taken   = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned cycle_count  = 0;
  int unsigned offered      = 0;
  int unsigned settings     = 0;

  periodic_dart_throw_checker DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results still pending",
               $time, cycle_count, sb.pending());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Receiver: drive tready at the falling edge. One long stall on request,
  // otherwise drop ready in about a third of the cycles unless calm is set.
  always @(negedge clk_i) begin
    if (hold_request && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      m_tready_i = 1'b0;
      hold_left--;
    end else begin
      m_tready_i = calm || ($urandom_range(0, 99) >= 33);
    end
  end

  // Check every result taken at a rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) sb.check_result(m_tdata_o);
  end

  // Offer one candidate, starting and ending just after a falling edge.
  // Tvalid stays high into the next request unless a gap is drawn.
  task automatic offer(bit restart, logic [COORD_BITS-1:0] cx,
                       logic [COORD_BITS-1:0] cy, logic [COORD_BITS-1:0] cz);
    while (!calm && $urandom_range(0, 99) < 33) begin
      s_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_tvalid_i = 1'b1;
    s_tuser_i  = restart;
    s_tdata_i  = IN_TDATA_W'({cz, cy, cx});
    do @(posedge clk_i); while (!s_tready_o);
    sb.note_candidate(restart, cx, cy, cz);
    offered++;
    @(negedge clk_i);
  endtask

  // Drop tvalid and hold until every queued outcome has come back.
  task automatic settle();
    s_tvalid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_register(cfg_reg_e idx, int unsigned value);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = value[CFG_W-1:0];
    sb.set_register(idx, value[CFG_W-1:0]);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Reprogram all registers once the block is idle.
  task automatic configure(int unsigned target, int unsigned bx, int unsigned by,
                           int unsigned bz, int unsigned rad);
    settle();
    write_register(REG_TARGET, target);
    write_register(REG_BOX_X, bx);
    write_register(REG_BOX_Y, by);
    write_register(REG_BOX_Z, bz);
    write_register(REG_RADIUS, rad);
    settings++;
  endtask

  // Inside coordinates mostly; noise lands past the edge or anywhere in 16 bits.
  function automatic logic [COORD_BITS-1:0] pick_coord(int unsigned len, bit noise);
    if (noise) begin
      if (len < 65535 && $urandom_range(0, 1) == 1) return COORD_BITS'(len + 1);
      return COORD_BITS'($urandom_range(0, 65535));
    end
    if ($urandom_range(0, 15) == 0) return COORD_BITS'(len);  // right on the edge
    return COORD_BITS'($urandom_range(0, len));
  endfunction

  // Random candidates in the current box, with some restarts and some noise.
  task automatic throw_darts(int n, int unsigned restart_pct, int unsigned noise_pct,
                             bit first_restart);
    bit restart;
    bit noise;
    for (int i = 0; i < n; i++) begin
      restart = (i == 0 && first_restart) || ($urandom_range(0, 99) < restart_pct);
      noise   = ($urandom_range(0, 99) < noise_pct);
      offer(restart, pick_coord(sb.box_len[0], noise), pick_coord(sb.box_len[1], noise),
            pick_coord(sb.box_len[2], noise));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (4) @(negedge clk_i);

    // Reset settings: target 1, box 5.0, radius 1.0.
    offer(1'b0, 16'd0, 16'd0, 16'd0);            // placed, set now full
    offer(1'b0, 16'd640, 16'd640, 16'd640);      // set full
    offer(1'b0, 16'd1281, 16'd0, 16'd0);         // outside wins over full
    offer(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);   // outside on every axis
    offer(1'b1, 16'd1280, 16'd1280, 16'd1280);   // restart; edge counts as inside

    configure(8, 1280, 1280, 1280, 256);
    offer(1'b1, 16'd0, 16'd0, 16'd0);
    offer(1'b0, 16'd1280, 16'd0, 16'd0);         // too close across the wrap
    offer(1'b0, 16'd640, 16'd640, 16'd0);        // half box on two axes: clear
    offer(1'b0, 16'd768, 16'd0, 16'd0);          // wraps to 512: too close

    configure(8, 65535, 65535, 65535, 256);
    offer(1'b1, 16'd0, 16'd0, 16'd0);
    offer(1'b0, 16'd768, 16'd0, 16'd0);          // exactly three radii: placed
    offer(1'b0, 16'd1535, 16'd0, 16'd0);
    offer(1'b0, 16'd65535, 16'd0, 16'd0);        // wraps next to the origin
    offer(1'b0, 16'hAAAA, 16'h5555, 16'hAAAA);

    // Zero-length y axis; some stored particles now lie past the shrunken box.
    configure(8, 4000, 0, 4000, 256);
    offer(1'b0, 16'd2000, 16'd0, 16'd2000);
    offer(1'b0, 16'd2000, 16'd1, 16'd2000);      // outside on y

    configure(0, 4000, 4000, 4000, 256);         // zero target: always full
    offer(1'b0, 16'd10, 16'd10, 16'd10);
    offer(1'b1, 16'd10, 16'd10, 16'd10);

    configure(8, 4000, 4000, 4000, 0);           // zero radius: nothing is too close
    offer(1'b1, 16'd5, 16'd5, 16'd5);
    offer(1'b0, 16'd5, 16'd5, 16'd5);

    // Mixed placement; stall the receiver long enough to back up the input.
    configure(20, 2560, 2560, 2560, 200);
    throw_darts(10, 5, 15, 1'b1);
    hold_request = 1'b1;
    throw_darts(110, 5, 15, 1'b0);

    // Fill all slots with a target above capacity, no idling anywhere.
    configure(511, 65535, 65535, 65535, 0);
    calm = 1'b1;
    throw_darts(270, 0, 0, 1'b1);
    calm = 1'b0;

    // Place in a large box, then shrink it without a restart.
    configure(40, 30000, 30000, 30000, 1000);
    throw_darts(30, 0, 10, 1'b1);
    configure(40, 8000, 8000, 8000, 300);
    throw_darts(60, 3, 15, 1'b0);

    configure(0, 4096, 4096, 4096, 100);
    throw_darts(20, 20, 30, 1'b0);

    configure(256, 0, 300, 65535, 5);
    throw_darts(60, 5, 20, 1'b1);

    // Widest radii: almost everything after the first particle is too close.
    configure(3, 65535, 65535, 65535, 32767);
    throw_darts(15, 10, 0, 1'b1);
    configure(3, 65535, 65535, 65535, 21845);
    throw_darts(15, 20, 0, 1'b1);

    // Long random run; pause the sender once until every result is back.
    configure(256, 4000, 4000, 4000, 64);
    throw_darts(75, 5, 15, 1'b1);
    settle();
    throw_darts(75, 5, 15, 1'b0);

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Covered %0d candidates over %0d register settings after reset defaults.",
             offered, settings);
    $display("Verdicts: %0d placed, %0d too close, %0d set full, %0d outside box.",
             sb.verdict_tally[VERDICT_PLACED], sb.verdict_tally[VERDICT_TOO_CLOSE],
             sb.verdict_tally[VERDICT_SET_FULL], sb.verdict_tally[VERDICT_OUTSIDE]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/pdtc_pkg.sv
rtl/pdtc_cell.sv
rtl/pdtc_dist.sv
rtl/periodic_dart_throw_checker.sv
tb/sv/pdtc_scoreboard_pkg.sv
tb/sv/tb_top.sv
